// ===== design/gdps_pkg.sv =====
`default_nettype none
package gdps_pkg;

  // Table geometry
  localparam int NUM_CLASSES = 20;
  localparam int ClassW      = 5;
  localparam int TableDepth  = NUM_CLASSES * NUM_CLASSES;
  localparam int IdxW        = $clog2(TableDepth);
  localparam int GateW       = 16;
  localparam int EntryW      = GateW + 1;

  // Datapath widths
  localparam int CoordW = 24;
  localparam int DiffW  = CoordW + 1;
  localparam int SqW    = 2 * DiffW;
  localparam int RadW   = 2 * GateW;
  localparam int RootW  = GateW;
  localparam int RemW   = RootW + 4;
  localparam int ScoreW = 16;

  // Iterative units: two result bits per pipeline stage
  localparam int SqSteps  = 2;
  localparam int SqStages = RootW / SqSteps;
  localparam int DvSteps  = 2;
  localparam int DvStages = ScoreW / DvSteps;

  localparam logic [ScoreW-1:0] ScoreMax = '1;

  // Command codes
  typedef enum logic {
    CmdLoad  = 1'b0,
    CmdScore = 1'b1
  } gdps_cmd_e;

  // Side information that travels with each item
  typedef struct packed {
    logic             valid;
    logic             allowed;
    logic             beyond;
    logic             dist_zero;
    logic [GateW-1:0] gate;
  } gdps_meta_t;

endpackage
`default_nettype wire

// ===== design/gdps_ram.sv =====
`default_nettype none
module gdps_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

// ===== design/gdps_sqrt.sv =====
`default_nettype none
module gdps_sqrt (
  input  wire logic                      clk_i,
  input  wire logic                      en_i,
  input  wire logic [gdps_pkg::RadW-1:0]  rad_i,
  output logic      [gdps_pkg::RootW-1:0] root_o
);
  import gdps_pkg::*;

  logic [RemW-1:0]  rem_q  [SqStages];
  logic [RootW-1:0] root_q [SqStages];
  logic [RadW-1:0]  rad_q  [SqStages];

  for (genvar g = 0; g < SqStages; g++) begin : g_stage
    logic [RemW-1:0]  rem_in, rem_t, trial;
    logic [RootW-1:0] root_in, root_t;
    logic [RadW-1:0]  rad_in, rad_t;

    if (g == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad_i;
    end else begin : g_next
      assign rem_in  = rem_q[g-1];
      assign root_in = root_q[g-1];
      assign rad_in  = rad_q[g-1];
    end

    // Resolve two root bits per stage
    always_comb begin
      rem_t  = rem_in;
      root_t = root_in;
      rad_t  = rad_in;
      trial  = '0;
      for (int k = 0; k < SqSteps; k++) begin
        rem_t = {rem_t[RemW-3:0], rad_t[RadW-1 -: 2]};
        rad_t = {rad_t[RadW-3:0], 2'b00};
        trial = RemW'({root_t, 2'b01});
        if (rem_t >= trial) begin
          rem_t  = rem_t - trial;
          root_t = {root_t[RootW-2:0], 1'b1};
        end else begin
          root_t = {root_t[RootW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g]  <= rem_t;
        root_q[g] <= root_t;
        rad_q[g]  <= rad_t;
      end
    end
  end

  assign root_o = root_q[SqStages-1];

endmodule
`default_nettype wire

// ===== design/gdps_div.sv =====
`default_nettype none
module gdps_div (
  input  wire logic                       clk_i,
  input  wire logic                       en_i,
  input  wire logic [gdps_pkg::GateW-1:0]  num_i,
  input  wire logic [gdps_pkg::GateW-1:0]  den_i,
  output logic      [gdps_pkg::ScoreW-1:0] quo_o
);
  import gdps_pkg::*;

  logic [GateW-1:0]  rem_q [DvStages];
  logic [GateW-1:0]  den_q [DvStages];
  logic [ScoreW-1:0] quo_q [DvStages];

  for (genvar g = 0; g < DvStages; g++) begin : g_stage
    logic [GateW-1:0]  rem_in, den_in;
    logic [ScoreW-1:0] quo_in, quo_t;
    logic [GateW:0]    rem_t;

    if (g == 0) begin : g_first
      assign rem_in = num_i;
      assign den_in = den_i;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_q[g-1];
      assign den_in = den_q[g-1];
      assign quo_in = quo_q[g-1];
    end

    // Restoring division, two quotient bits per stage
    always_comb begin
      rem_t = {1'b0, rem_in};
      quo_t = quo_in;
      for (int k = 0; k < DvSteps; k++) begin
        rem_t = {rem_t[GateW-1:0], 1'b0};
        if (rem_t >= {1'b0, den_in}) begin
          rem_t = rem_t - {1'b0, den_in};
          quo_t = {quo_t[ScoreW-2:0], 1'b1};
        end else begin
          quo_t = {quo_t[ScoreW-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g] <= rem_t[GateW-1:0];
        den_q[g] <= den_in;
        quo_q[g] <= quo_t;
      end
    end
  end

  assign quo_o = quo_q[DvStages-1];

endmodule
`default_nettype wire

// ===== design/gated_distance_pair_score.sv =====
// Gated Euclidean distance pair score.
// Input channel (in_valid_i/in_ready_o) takes one command item per cycle. A load
// (command 0) writes the allowed flag and gate distance of one class pair into a
// 400-entry table RAM and yields no result. A score (command 1) reads the entry for
// (class_a, class_b), squares the centroid offsets, takes an integer square root
// and divides the remaining gate margin by the gate to form a Q0.16 score.
// Output channel (out_valid_o/out_ready_i) carries score, pair_allowed, beyond_gate.
// Pipeline: RAM read alongside the offsets, multiply, add/compare, 8 square-root stages,
// 8 divider stages, output register. Throughput: one item per cycle while the output
// is not stalled; every stage, the RAM read port included, is fully pipelined and a
// load may be followed by a score of the same entry at once. When the receiver stalls,
// the whole pipeline holds and in_ready_o drops until the waiting result is taken.
// Reset clears all valid flags; table contents stay undefined until loaded, and no
// clearing pass is run.
`default_nettype none
module gated_distance_pair_score (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_ready_o,
  input  wire logic                         command_i,
  input  wire logic [gdps_pkg::ClassW-1:0]  class_a_i,
  input  wire logic [gdps_pkg::ClassW-1:0]  class_b_i,
  input  wire logic signed [gdps_pkg::CoordW-1:0] first_x_i,
  input  wire logic signed [gdps_pkg::CoordW-1:0] first_y_i,
  input  wire logic signed [gdps_pkg::CoordW-1:0] second_x_i,
  input  wire logic signed [gdps_pkg::CoordW-1:0] second_y_i,
  input  wire logic                         load_allowed_i,
  input  wire logic [gdps_pkg::GateW-1:0]   load_max_distance_i,
  output logic                              out_valid_o,
  input  wire logic                         out_ready_i,
  output logic      [gdps_pkg::ScoreW-1:0]  score_o,
  output logic                              pair_allowed_o,
  output logic                              beyond_gate_o
);
  import gdps_pkg::*;

  logic             adv, accept, in_range;
  logic [IdxW-1:0]  idx;
  logic [EntryW-1:0] entry;

  // Pipeline advances unless a finished result is waiting
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;
  assign accept     = in_valid_i && adv;

  // Table address
  assign in_range = ({1'b0, class_a_i} < (ClassW+1)'(NUM_CLASSES)) &&
                    ({1'b0, class_b_i} < (ClassW+1)'(NUM_CLASSES));
  assign idx = IdxW'(IdxW'(class_a_i) * IdxW'(NUM_CLASSES)) + IdxW'(class_b_i);

  gdps_ram #(
    .Width (EntryW),
    .Depth (TableDepth)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (accept && (command_i == CmdLoad) && in_range),
    .waddr_i (idx),
    .wdata_i ({load_allowed_i, load_max_distance_i}),
    .re_i    (adv),
    .raddr_i (idx),
    .rdata_o (entry)
  );

  // Stage 1: offsets
  logic                    v1_q, inr1_q;
  logic signed [DiffW-1:0] dx1_q, dy1_q;

  // Stage 2: squares
  logic              v2_q, allowed2_q;
  logic [SqW-1:0]    sqx2_q, sqy2_q;
  logic [RadW-1:0]   mm2_q;
  logic [GateW-1:0]  m2_q;
  logic [DiffW-1:0]  ax, ay;

  // Stage 3: sum and gate compare
  logic [SqW:0]      d2;
  logic [RadW-1:0]   d2_q;
  gdps_meta_t        m3_q;

  // Meta alongside the iterative units
  gdps_meta_t        msq_q [SqStages];
  gdps_meta_t        mdv_q [DvStages];
  gdps_meta_t        mdv_in;
  logic [RootW-1:0]  root;
  logic [ScoreW-1:0] quo;

  assign ax = dx1_q[DiffW-1] ? DiffW'(-dx1_q) : DiffW'(dx1_q);
  assign ay = dy1_q[DiffW-1] ? DiffW'(-dy1_q) : DiffW'(dy1_q);
  assign d2 = {1'b0, sqx2_q} + {1'b0, sqy2_q};

  // Control: valid flags and side information
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      m3_q <= '0;
      for (int i = 0; i < SqStages; i++) msq_q[i] <= '0;
      for (int i = 0; i < DvStages; i++) mdv_q[i] <= '0;
      out_valid_o <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i && (command_i == CmdScore);
      v2_q <= v1_q;
      m3_q.valid     <= v2_q;
      m3_q.allowed   <= allowed2_q;
      m3_q.beyond    <= allowed2_q && (d2 > (SqW+1)'(mm2_q));
      m3_q.dist_zero <= 1'b0;
      m3_q.gate      <= m2_q;
      msq_q[0] <= m3_q;
      for (int i = 1; i < SqStages; i++) msq_q[i] <= msq_q[i-1];
      mdv_q[0] <= mdv_in;
      for (int i = 1; i < DvStages; i++) mdv_q[i] <= mdv_q[i-1];
      out_valid_o <= mdv_q[DvStages-1].valid;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (adv) begin
      inr1_q     <= in_range;
      dx1_q      <= DiffW'(second_x_i) - DiffW'(first_x_i);
      dy1_q      <= DiffW'(second_y_i) - DiffW'(first_y_i);
      allowed2_q <= inr1_q && entry[GateW];
      m2_q       <= entry[GateW-1:0];
      mm2_q      <= RadW'(entry[GateW-1:0]) * RadW'(entry[GateW-1:0]);
      sqx2_q     <= SqW'(ax) * SqW'(ax);
      sqy2_q     <= SqW'(ay) * SqW'(ay);
      d2_q       <= d2[RadW-1:0];
    end
  end

  gdps_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .rad_i  (d2_q),
    .root_o (root)
  );

  // Mark zero distance as the divider takes the margin
  always_comb begin
    mdv_in           = msq_q[SqStages-1];
    mdv_in.dist_zero = (root == '0);
  end

  gdps_div u_div (
    .clk_i (clk_i),
    .en_i  (adv),
    .num_i (mdv_in.gate - root),
    .den_i (mdv_in.gate),
    .quo_o (quo)
  );

  // Output register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pair_allowed_o <= mdv_q[DvStages-1].allowed;
      beyond_gate_o  <= mdv_q[DvStages-1].beyond;
      if (!mdv_q[DvStages-1].allowed || mdv_q[DvStages-1].beyond ||
          (mdv_q[DvStages-1].gate == '0)) begin
        score_o <= '0;
      end else if (mdv_q[DvStages-1].dist_zero) begin
        score_o <= ScoreMax;
      end else begin
        score_o <= quo;
      end
    end
  end

endmodule
`default_nettype wire

// ===== design/gdps_checker.sv =====
`default_nettype none
module gdps_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_ready_o,
  input wire logic                        out_valid_o,
  input wire logic                        out_ready_i,
  input wire logic [gdps_pkg::ScoreW-1:0] score_o,
  input wire logic                        pair_allowed_o,
  input wire logic                        beyond_gate_o
);

  // Held result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // Stall reaches the input side
  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("input accepted during output stall");

  // Disallowed pair scores zero and is never gated
  a_not_allowed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !pair_allowed_o |-> (score_o == '0) && !beyond_gate_o)
    else $error("disallowed pair with nonzero result");

  // Beyond gate scores zero
  a_beyond_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && beyond_gate_o |-> score_o == '0)
    else $error("gated pair with nonzero score");

endmodule

bind gated_distance_pair_score gdps_checker u_gdps_checker (.*);
`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import gdps_pkg::*;

  localparam int CycleLimit = 400000;
  localparam int DrainCycles = 40;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic command_i = 1'b0;
  logic [ClassW-1:0] class_a_i = '0;
  logic [ClassW-1:0] class_b_i = '0;
  logic signed [CoordW-1:0] first_x_i = '0;
  logic signed [CoordW-1:0] first_y_i = '0;
  logic signed [CoordW-1:0] second_x_i = '0;
  logic signed [CoordW-1:0] second_y_i = '0;
  logic load_allowed_i = 1'b0;
  logic [GateW-1:0] load_max_distance_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [ScoreW-1:0] score_o;
  logic pair_allowed_o;
  logic beyond_gate_o;

  typedef struct packed {
    logic [ScoreW-1:0] score;
    logic allowed;
    logic beyond;
  } score_t;

  // Predictor copy of the class-pair table and which entries were loaded
  logic [EntryW-1:0] gate_table [TableDepth];
  bit loaded [TableDepth];
  score_t expected_scores[$];
  int mismatches = 0;
  int cycles = 0;
  bit fail_seen = 1'b0;
  bit idle_enable = 1'b1;
  bit sink_hold = 1'b0;

  always #10 clk_i = ~clk_i;

  gated_distance_pair_score uut (.*);

  // Bit-serial integer square root, floor
  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic score_t predict_score(input logic [ClassW-1:0] ca, input logic [ClassW-1:0] cb,
                                           input logic signed [CoordW-1:0] fx,
                                           input logic signed [CoordW-1:0] fy,
                                           input logic signed [CoordW-1:0] sx,
                                           input logic signed [CoordW-1:0] sy);
    score_t r;
    logic [EntryW-1:0] e;
    longint dx, dy;
    logic [63:0] d2, m, d, q;
    r = '0;
    e = '0;
    if (ca < NUM_CLASSES && cb < NUM_CLASSES) e = gate_table[ca * NUM_CLASSES + cb];
    r.allowed = e[GateW];
    if (r.allowed) begin
      dx = longint'(sx) - longint'(fx);
      dy = longint'(sy) - longint'(fy);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      d2 = dx * dx + dy * dy;
      m = e[GateW-1:0];
      if (d2 > m * m) begin
        r.beyond = 1'b1;
      end else if (m != 0) begin
        d = int_sqrt(d2);
        q = ((m - d) << 16) / m;
        r.score = (q > 65535) ? ScoreMax : q[ScoreW-1:0];
      end
    end
    return r;
  endfunction

  // Offer one item and hold it until accepted
  task automatic send_item(input gdps_cmd_e cmd, input logic [ClassW-1:0] ca,
                           input logic [ClassW-1:0] cb,
                           input logic signed [CoordW-1:0] fx,
                           input logic signed [CoordW-1:0] fy,
                           input logic signed [CoordW-1:0] sx,
                           input logic signed [CoordW-1:0] sy,
                           input logic al, input logic [GateW-1:0] md);
    while (idle_enable && $urandom_range(99) < 21) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i <= cmd;
    class_a_i <= ca;
    class_b_i <= cb;
    first_x_i <= fx;
    first_y_i <= fy;
    second_x_i <= sx;
    second_y_i <= sy;
    load_allowed_i <= al;
    load_max_distance_i <= md;
    do @(posedge clk_i); while (!in_ready_o);
    if (cmd == CmdLoad) begin
      if (ca < NUM_CLASSES && cb < NUM_CLASSES) begin
        gate_table[ca * NUM_CLASSES + cb] = {al, md};
        loaded[ca * NUM_CLASSES + cb] = 1'b1;
      end
    end else begin
      expected_scores.push_back(predict_score(ca, cb, fx, fy, sx, sy));
    end
  endtask

  task automatic load_entry(input int ca, input int cb, input logic al,
                            input logic [GateW-1:0] md);
    send_item(CmdLoad, ClassW'(ca), ClassW'(cb), CoordW'($urandom), CoordW'($urandom),
              CoordW'($urandom), CoordW'($urandom), al, md);
  endtask

  task automatic score_pair(input int ca, input int cb, input logic signed [CoordW-1:0] fx,
                            input logic signed [CoordW-1:0] fy,
                            input logic signed [CoordW-1:0] sx,
                            input logic signed [CoordW-1:0] sy);
    send_item(CmdScore, ClassW'(ca), ClassW'(cb), fx, fy, sx, sy, 1'($urandom),
              GateW'($urandom));
  endtask

  // Random offset that lands near the gate most of the time
  function automatic int near_offset(input int m);
    case ($urandom_range(3))
      0: return $urandom_range(0, m);
      1: return m + $urandom_range(0, 4) - 2;
      2: return $urandom_range(0, 2 * m + 2);
      default: return int'($urandom_range(0, 32'hFFFFFF)) - 32'h800000;
    endcase
  endfunction

  // Drop the input and wait for every expected result
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_scores.size() != 0) @(posedge clk_i);
  endtask

  // Extremes: coincident centroids, full-scale offsets, zero gate, blocked pair, out-of-range classes
  task automatic test_directed();
    load_entry(0, 0, 1'b1, 16'hFFFF);
    load_entry(19, 19, 1'b1, 16'd0);
    load_entry(19, 0, 1'b0, 16'd1000);
    load_entry(0, 19, 1'b1, 16'd1);
    score_pair(0, 0, 0, 0, 0, 0);
    score_pair(0, 0, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000);
    score_pair(0, 0, 24'h800000, 24'h7FFFFF, 24'h7FFFFF, 24'h800000);
    score_pair(0, 0, 0, 0, 16'hFFFF, 0);
    score_pair(0, 0, 0, 0, 16'hFFFE, 1);
    score_pair(19, 19, 5, 5, 5, 5);
    score_pair(19, 19, 5, 5, 6, 5);
    score_pair(19, 0, 0, 0, 3, 4);
    score_pair(0, 19, 0, 0, 1, 0);
    score_pair(0, 19, 0, 0, 1, 1);
    score_pair(0, 19, -1, -1, -1, -1);
    score_pair(20, 0, 0, 0, 0, 0);
    score_pair(0, 31, 0, 0, 0, 0);
    send_item(CmdLoad, 31, 31, 0, 0, 0, 0, 1'b1, 16'hFFFF);
    send_item(CmdLoad, 0, 20, 0, 0, 0, 0, 1'b1, 16'hFFFF);
    score_pair(0, 0, 100, -100, -200, 300);
    // Load followed at once by a score of the same entry
    load_entry(0, 0, 1'b1, 16'd500);
    score_pair(0, 0, 0, 0, 300, 400);
  endtask

  // Random loads mixed with mostly valid scores of loaded entries
  task automatic test_random(input int n_items);
    int ca, cb, m, idx;
    logic signed [CoordW-1:0] fx, fy;
    for (int i = 0; i < n_items; i++) begin
      ca = $urandom_range(NUM_CLASSES - 1);
      cb = $urandom_range(NUM_CLASSES - 1);
      if ($urandom_range(9) < 2 || !loaded[ca * NUM_CLASSES + cb]) begin
        load_entry(ca, cb, $urandom_range(9) < 8,
                   ($urandom_range(9) == 0) ? 16'($urandom_range(0, 2)) : 16'($urandom));
      end else if ($urandom_range(19) == 0) begin
        score_pair(NUM_CLASSES + $urandom_range(31 - NUM_CLASSES), $urandom_range(31),
                   CoordW'($urandom), CoordW'($urandom), CoordW'($urandom),
                   CoordW'($urandom));
      end else begin
        idx = ca * NUM_CLASSES + cb;
        m = int'(gate_table[idx][GateW-1:0]);
        fx = CoordW'($urandom);
        fy = CoordW'($urandom);
        score_pair(ca, cb, fx, fy,
                   CoordW'(fx + near_offset(m) * ($urandom_range(1) ? 1 : -1)),
                   CoordW'(fy + near_offset(m) / 2 * ($urandom_range(1) ? 1 : -1)));
      end
    end
  endtask

  // Stall the output long enough to fill the pipeline and block the input, then drain and run without idle gaps
  task automatic test_backpressure();
    sink_hold = 1'b1;
    idle_enable = 1'b0;
    fork
      begin
        test_random(60);
        in_valid_i <= 1'b0;
      end
      begin
        repeat (150) @(posedge clk_i);
        sink_hold = 1'b0;
      end
    join
    wait_drained();
    test_random(120);
    idle_enable = 1'b1;
  endtask

  // Output readiness
  always @(posedge clk_i) begin
    out_ready_i <= !sink_hold && !(idle_enable && $urandom_range(99) < 21);
  end

  // Compare each result with the oldest expectation
  always @(posedge clk_i) begin
    score_t exp_r;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_scores.size() == 0) begin
        fail_seen = 1'b1;
        mismatches++;
        if (mismatches <= 10) $display("unexpected result score=%0d", score_o);
      end else begin
        exp_r = expected_scores.pop_front();
        if (exp_r != {score_o, pair_allowed_o, beyond_gate_o}) begin
          fail_seen = 1'b1;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected score=%0d allowed=%0b beyond=%0b, got %0d %0b %0b",
                     exp_r.score, exp_r.allowed, exp_r.beyond,
                     score_o, pair_allowed_o, beyond_gate_o);
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("gated_distance_pair_score regression: fail");
      $finish;
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(250);
    test_backpressure();
    wait_drained();
    test_random(150);
    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (!fail_seen && expected_scores.size() == 0) begin
      $display("gated_distance_pair_score regression: pass");
    end else begin
      $display("gated_distance_pair_score regression: fail");
    end
    $finish;
  end

endmodule
